[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the image header validator.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop on every rising clk edge outside reset
`define AIHV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition never holds outside reset
`define AIHV_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/core/aihv_pkg.sv]
// Package of the image header validator: constants, codes, shared types.
// Depends on nothing; used by the parser, the top level and the testbench.
`timescale 1ns / 1ps

package aihv_pkg;

	localparam int MAX_ENTRIES = 128;
	localparam logic [31:0] IMAGE_MAGIC = 32'h3153_4652;
	localparam logic [31:0] HEADER_BYTES = 32'd8;
	localparam logic [31:0] RECORD_BYTES = 32'd12;
	localparam logic [15:0] PATH_LIMIT = 16'd255;

	typedef enum logic [2:0] {
		ERR_OK      = 3'd0,
		ERR_SMALL   = 3'd1,
		ERR_MAGIC   = 3'd2,
		ERR_COUNT   = 3'd3,
		ERR_RECORD  = 3'd4,
		ERR_PATH    = 3'd5,
		ERR_DATA    = 3'd6
	} aihv_err_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_RECORD,
		PH_PATH,
		PH_DONE
	} aihv_phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} aihv_item_t;

	typedef struct packed {
		logic       emit;
		logic       image_ok;
		logic [2:0] error_kind;
		logic [7:0] entry_count;
		logic [6:0] bad_entry;
	} aihv_verdict_t;

	function automatic logic in_image(logic [31:0] offset, logic [31:0] length,
		logic [31:0] size);
		return (offset <= size) && (length <= (size - offset));
	endfunction

endpackage

[rtl/core/aihv_channels.sv]
// Valid/ready channel interfaces for image bytes and verdicts.
// Depends on nothing beyond plain logic types.
`timescale 1ns / 1ps

interface aihv_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;

	modport source (output valid, output data_byte, output first_byte, input ready);
	modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface aihv_verdict_if;
	logic       valid;
	logic       ready;
	logic       image_ok;
	logic [2:0] error_kind;
	logic [7:0] entry_count;
	logic [6:0] bad_entry;

	modport source (output valid, output image_ok, output error_kind, output entry_count,
		output bad_entry, input ready);
	modport sink (input valid, input image_ok, input error_kind, input entry_count,
		input bad_entry, output ready);
endinterface

[rtl/core/aihv_parser.sv]
// Header and entry-table parser: parse state, field capture and range checks.
// Depends on aihv_pkg; processes one byte per cycle when go is high.
`timescale 1ns / 1ps

module aihv_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  aihv_pkg::aihv_item_t   item,
	input  logic [31:0]            image_size,
	output aihv_pkg::aihv_verdict_t verdict
);
	import aihv_pkg::*;

	aihv_phase_t phase_q, phase_d;
	logic [3:0]  bif_q, bif_d;
	logic [31:0] cursor_q, cursor_d;
	logic [31:0] shift_q, shift_d;
	logic [7:0]  declared_q, declared_d;
	logic [7:0]  checked_q, checked_d;
	logic [15:0] plen_q, plen_d;
	logic [31:0] doff_q, doff_d;
	logic [7:0]  left_q, left_d;

	logic      emit;
	aihv_err_t kind;

	always_comb begin
		logic        active;
		logic [3:0]  bif;
		logic [31:0] cur;
		logic [31:0] ws;
		logic [7:0]  decl;
		logic [7:0]  chk;
		logic [15:0] plen;
		logic [31:0] doff;
		logic [7:0]  left;

		emit = 1'b0;
		kind = ERR_OK;
		bif  = bif_q;
		cur  = cursor_q;
		ws   = shift_q;
		decl = declared_q;
		chk  = checked_q;
		plen = plen_q;
		doff = doff_q;
		left = left_q;
		active = 1'b0;

		if (go) begin
			if (item.first_byte) begin
				bif  = '0;
				cur  = '0;
				ws   = '0;
				decl = '0;
				chk  = '0;
				plen = '0;
				doff = '0;
				left = '0;
				if (image_size < HEADER_BYTES) begin
					emit = 1'b1;
					kind = ERR_SMALL;
				end else begin
					active = 1'b1;
				end
			end else begin
				active = (phase_q == PH_HEADER) || (phase_q == PH_RECORD)
					|| (phase_q == PH_PATH);
			end
		end

		if (active) begin
			ws  = {item.data_byte, ws[31:8]};
			cur = cur + 32'd1;
			case (item.first_byte ? PH_HEADER : phase_q)
				PH_HEADER: begin
					if (bif == 4'd3 && ws != IMAGE_MAGIC) begin
						emit = 1'b1;
						kind = ERR_MAGIC;
					end else if (bif == 4'd7) begin
						if (ws == 32'd0 || ws > 32'(MAX_ENTRIES)) begin
							emit = 1'b1;
							kind = ERR_COUNT;
						end else begin
							decl = ws[7:0];
							chk  = '0;
							bif  = '0;
							if (!in_image(cur, RECORD_BYTES, image_size)) begin
								emit = 1'b1;
								kind = ERR_RECORD;
							end
						end
					end else begin
						bif = bif + 4'd1;
					end
				end
				PH_RECORD: begin
					if (bif == 4'd1)
						plen = ws[31:16];
					if (bif == 4'd7)
						doff = ws;
					if (bif == 4'd11) begin
						if (plen == 16'd0 || plen > PATH_LIMIT
							|| !in_image(cur, {16'd0, plen}, image_size)) begin
							emit = 1'b1;
							kind = ERR_PATH;
						end else if (!in_image(doff, ws, image_size)) begin
							emit = 1'b1;
							kind = ERR_DATA;
						end else begin
							left = plen[7:0];
						end
					end else begin
						bif = bif + 4'd1;
					end
				end
				PH_PATH: begin
					left = left - 8'd1;
					if (left == 8'd0) begin
						chk = chk + 8'd1;
						if (chk >= decl) begin
							emit = 1'b1;
							kind = ERR_OK;
						end else begin
							bif = '0;
							if (!in_image(cur, RECORD_BYTES, image_size)) begin
								emit = 1'b1;
								kind = ERR_RECORD;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end

		bif_d      = bif;
		cursor_d   = cur;
		shift_d    = ws;
		declared_d = decl;
		checked_d  = chk;
		plen_d     = plen;
		doff_d     = doff;
		left_d     = left;
	end

	always_comb begin
		phase_d = phase_q;
		if (go) begin
			if (emit) begin
				phase_d = PH_DONE;
			end else if (item.first_byte) begin
				phase_d = PH_HEADER;
			end else begin
				case (phase_q)
					PH_HEADER: begin
						if (bif_q == 4'd7)
							phase_d = PH_RECORD;
					end
					PH_RECORD: begin
						if (bif_q == 4'd11)
							phase_d = PH_PATH;
					end
					PH_PATH: begin
						if (left_q == 8'd1)
							phase_d = PH_RECORD;
					end
					default: phase_d = phase_q;
				endcase
			end
		end
	end

	always_comb begin
		verdict.emit        = emit;
		verdict.image_ok    = (kind == ERR_OK);
		verdict.error_kind  = kind;
		verdict.entry_count = (kind == ERR_OK) ? declared_d : 8'd0;
		verdict.bad_entry   = (kind == ERR_RECORD || kind == ERR_PATH || kind == ERR_DATA)
			? checked_d[6:0] : 7'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			bif_q      <= '0;
			cursor_q   <= '0;
			shift_q    <= '0;
			declared_q <= '0;
			checked_q  <= '0;
			plen_q     <= '0;
			doff_q     <= '0;
			left_q     <= '0;
		end else if (go) begin
			phase_q    <= phase_d;
			bif_q      <= bif_d;
			cursor_q   <= cursor_d;
			shift_q    <= shift_d;
			declared_q <= declared_d;
			checked_q  <= checked_d;
			plen_q     <= plen_d;
			doff_q     <= doff_d;
			left_q     <= left_d;
		end
	end

endmodule

[rtl/core/archive_image_header_validator_unit.sv]
// Image header validator top: a byte goes from its transfer through the input register,
// the single-pass parser and the verdict register to its verdict transfer. One byte per
// cycle while the verdict output is not stalled; at most one verdict per image.
// arst_n clears the parse state, both stage valids and image_size to zero.
// Depends on aihv_pkg, aihv_channels, aihv_parser and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module archive_image_header_validator_unit (
	input  logic        clk,
	input  logic        arst_n,
	aihv_byte_if.sink   byte_ch,
	aihv_verdict_if.source verdict_ch,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);
	import aihv_pkg::*;

	logic          valid_s1;
	aihv_item_t    item_s1;
	logic          out_valid_q;
	aihv_verdict_t out_q;
	logic [31:0]   image_size_q;
	logic          advance;
	logic          go;
	aihv_verdict_t verdict;
	logic          ok_fields;

	assign advance      = !out_valid_q || verdict_ch.ready;
	assign byte_ch.ready = !valid_s1 || advance;
	assign go           = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= '0;
		end else if (cfg_wr_en) begin
			image_size_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.valid && byte_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			item_s1.data_byte  <= byte_ch.data_byte;
			item_s1.first_byte <= byte_ch.first_byte;
		end
	end

	aihv_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.item       (item_s1),
		.image_size (image_size_q),
		.verdict    (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= go && verdict.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (go && verdict.emit) begin
			out_q <= verdict;
		end
	end

	assign verdict_ch.valid       = out_valid_q;
	assign verdict_ch.image_ok    = out_q.image_ok;
	assign verdict_ch.error_kind  = out_q.error_kind;
	assign verdict_ch.entry_count = out_q.entry_count;
	assign verdict_ch.bad_entry   = out_q.bad_entry;

	assign ok_fields = out_q.entry_count != 8'd0 && out_q.bad_entry == 7'd0
		&& out_q.error_kind == ERR_OK;

	`AIHV_ASSERT(a_emit_reaches_out, go && verdict.emit |=> out_valid_q, "verdict dropped")
	`AIHV_ASSERT(a_ok_fields, out_valid_q && out_q.image_ok |-> ok_fields, "bad ok verdict")
	`AIHV_NEVER(a_stall_only_full, !byte_ch.ready && !(valid_s1 && out_valid_q), "early stall")

endmodule

[bench/tb_archive_image_header_validator_unit.sv]
// Testbench of archive_image_header_validator_unit: streams images byte by byte,
// predicts at most one verdict per image and checks each verdict transfer in order.
// Depends on aihv_pkg, the aihv_byte_if/aihv_verdict_if interfaces and the RTL.
`timescale 1ns / 1ps

module tb_archive_image_header_validator_unit;
	import aihv_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int TOTAL_ITEMS = 1850;
	localparam int SETTLE_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 500;

	typedef struct packed {
		logic       ok;
		aihv_err_t  kind;
		logic [7:0] count;
		logic [6:0] bad;
	} verdict_t;

	typedef enum {
		FLT_NONE,
		FLT_PLEN_ZERO,
		FLT_PLEN_HUGE,
		FLT_DATA_RANGE,
		FLT_PATH_AND_DATA
	} table_fault_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;

	aihv_byte_if    byte_ch ();
	aihv_verdict_if verdict_ch ();

	archive_image_header_validator_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_ch     (byte_ch),
		.verdict_ch  (verdict_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// predictor state
	logic [31:0] size_cfg;
	aihv_phase_t parse_state;
	logic [3:0]  field_idx;
	logic [31:0] byte_pos;
	logic [31:0] shreg;
	logic [7:0]  tbl_entries;
	logic [7:0]  tbl_done;
	logic [15:0] cur_path_len;
	logic [31:0] cur_data_off;
	logic [7:0]  path_remaining;

	verdict_t    pending_verdicts[$];
	logic [7:0]  img[$];

	bit idle_on = 1'b1;
	int ready_hold = 0;
	int quiet_cycles = 0;
	int n_sent = 0;
	int n_parsed = 0;
	int n_images = 0;
	int n_predicted = 0;
	int n_results = 0;
	int n_mismatch = 0;
	int n_sizes = 0;
	int kind_seen[7];

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic bit fits(logic [31:0] off, logic [31:0] len);
		return (off <= size_cfg) && (len <= size_cfg - off);
	endfunction

	function automatic void issue(aihv_err_t kind);
		verdict_t v;
		v.ok = (kind == ERR_OK);
		v.kind = kind;
		v.count = (kind == ERR_OK) ? tbl_entries : 8'd0;
		v.bad = (kind >= ERR_RECORD) ? tbl_done[6:0] : 7'd0;
		pending_verdicts.push_back(v);
		n_predicted++;
		parse_state = PH_DONE;
	endfunction

	function automatic void open_record();
		if (!fits(byte_pos, RECORD_BYTES)) begin
			issue(ERR_RECORD);
		end else begin
			parse_state = PH_RECORD;
			field_idx = 4'd0;
		end
	endfunction

	function automatic void parse_byte(logic [7:0] b, logic first);
		if (!first && (parse_state == PH_IDLE || parse_state == PH_DONE))
			return;
		n_parsed++;
		if (first) begin
			n_images++;
			parse_state = PH_HEADER;
			field_idx = 4'd0;
			byte_pos = '0;
			shreg = '0;
			tbl_entries = '0;
			tbl_done = '0;
			cur_path_len = '0;
			cur_data_off = '0;
			path_remaining = '0;
			if (size_cfg < HEADER_BYTES) begin
				issue(ERR_SMALL);
				return;
			end
		end
		shreg = {b, shreg[31:8]};
		byte_pos = byte_pos + 32'd1;
		case (parse_state)
			PH_HEADER: begin
				if (field_idx == 4'd3 && shreg != IMAGE_MAGIC) begin
					issue(ERR_MAGIC);
				end else if (field_idx == 4'd7) begin
					if (shreg == 32'd0 || shreg > 32'(MAX_ENTRIES)) begin
						issue(ERR_COUNT);
					end else begin
						tbl_entries = shreg[7:0];
						tbl_done = 8'd0;
						open_record();
					end
				end else begin
					field_idx = field_idx + 4'd1;
				end
			end
			PH_RECORD: begin
				if (field_idx == 4'd1)
					cur_path_len = shreg[31:16];
				if (field_idx == 4'd7)
					cur_data_off = shreg;
				if (field_idx == 4'd11) begin
					if (cur_path_len == 16'd0 || cur_path_len > PATH_LIMIT
						|| !fits(byte_pos, {16'd0, cur_path_len})) begin
						issue(ERR_PATH);
					end else if (!fits(cur_data_off, shreg)) begin
						issue(ERR_DATA);
					end else begin
						path_remaining = cur_path_len[7:0];
						parse_state = PH_PATH;
					end
				end else begin
					field_idx = field_idx + 4'd1;
				end
			end
			PH_PATH: begin
				path_remaining = path_remaining - 8'd1;
				if (path_remaining == 8'd0) begin
					tbl_done = tbl_done + 8'd1;
					if (tbl_done >= tbl_entries)
						issue(ERR_OK);
					else
						open_record();
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void put_le(logic [31:0] v, int nbytes);
		for (int i = 0; i < nbytes; i++)
			img.push_back(v[8 * i +: 8]);
	endfunction

	function automatic logic [31:0] pick_upto(logic [31:0] limit);
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return limit;
			default: return (limit == '1) ? 32'($urandom) : $urandom % (limit + 32'd1);
		endcase
	endfunction

	function automatic void build_table(input logic [31:0] magic, input logic [31:0] count,
		input int n_rec, input int fault_at, input table_fault_t fault,
		input int min_plen, input int max_plen);
		logic [15:0] plen;
		logic [31:0] off, len;
		img.delete();
		put_le(magic, 4);
		put_le(count, 4);
		for (int i = 0; i < n_rec; i++) begin
			plen = 16'($urandom_range(min_plen, max_plen));
			off = pick_upto(size_cfg);
			len = pick_upto(size_cfg - off);
			if (i == fault_at) begin
				if (fault == FLT_PLEN_ZERO || fault == FLT_PATH_AND_DATA)
					plen = 16'd0;
				if (fault == FLT_PLEN_HUGE)
					plen = 16'($urandom_range(256, 65535));
				if (fault == FLT_DATA_RANGE || fault == FLT_PATH_AND_DATA) begin
					if (size_cfg == 32'd0 || (size_cfg != '1 && $urandom_range(0, 1))) begin
						off = size_cfg + 32'd1 + ($urandom % (~size_cfg));
						len = $urandom;
					end else begin
						off = 32'd1 + ($urandom % size_cfg);
						len = size_cfg - off + 32'd1 + ($urandom % off);
					end
				end
			end
			put_le({16'd0, plen}, 2);
			put_le($urandom, 2);
			put_le(off, 4);
			put_le(len, 4);
			if (plen != 16'd0 && plen <= PATH_LIMIT)
				for (int k = 0; k < plen; k++)
					img.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic first);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.first_byte <= first;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		n_sent++;
		parse_byte(b, first);
	endtask

	task automatic send_image(input int keep = -1);
		int n;
		n = (keep < 0 || keep > img.size()) ? img.size() : keep;
		for (int i = 0; i < n; i++)
			send_byte(img[i], i == 0);
	endtask

	task automatic send_noise(input int n);
		repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// hold off until every verdict is in and the pipeline is empty
	task automatic settle_block();
		byte_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_image_size(input logic [31:0] v);
		settle_block();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		size_cfg = v;
		n_sizes++;
	endtask

	task automatic report_mismatch(input string what, input verdict_t want, input verdict_t got);
		n_mismatch++;
		if (n_mismatch <= 10)
			$display("%0t %s: exp ok=%0b kind=%0d cnt=%0d bad=%0d, act ok=%0b kind=%0d cnt=%0d bad=%0d",
				$realtime, what, want.ok, want.kind, want.count, want.bad,
				got.ok, got.kind, got.count, got.bad);
	endtask

	task automatic test_ignored_bytes();
		send_noise(6);
	endtask

	task automatic test_too_small();
		set_image_size(32'd0);
		build_table(IMAGE_MAGIC, 32'd1, 1, -1, FLT_NONE, 1, 4);
		send_image();
		set_image_size(32'd7);
		send_image();
		send_byte(8'hFF, 1'b1);
	endtask

	task automatic test_header_checks();
		set_image_size(32'd4096);
		build_table(IMAGE_MAGIC ^ (32'd1 << $urandom_range(0, 31)), 32'd1, 1, -1, FLT_NONE, 1, 4);
		send_image();
		send_noise(4);
		build_table(IMAGE_MAGIC, 32'd0, 1, -1, FLT_NONE, 1, 4);
		send_image();
		build_table(IMAGE_MAGIC, 32'(MAX_ENTRIES) + 32'd1, 1, -1, FLT_NONE, 1, 4);
		send_image();
		build_table(IMAGE_MAGIC, 32'h0000_0100, 1, -1, FLT_NONE, 1, 4);
		send_image();
		build_table(IMAGE_MAGIC, '1, 1, -1, FLT_NONE, 1, 4);
		send_image();
		set_image_size(32'd8);
		build_table(IMAGE_MAGIC, 32'(MAX_ENTRIES), 1, -1, FLT_NONE, 1, 4);
		send_image();
	endtask

	task automatic test_record_bounds();
		set_image_size(32'd19);
		build_table(IMAGE_MAGIC, 32'd1, 1, -1, FLT_NONE, 1, 1);
		send_image();
		set_image_size(32'd20);
		send_image();
		set_image_size(32'd21);
		build_table(IMAGE_MAGIC, 32'd2, 2, -1, FLT_NONE, 1, 1);
		send_image();
		build_table(IMAGE_MAGIC, 32'd1, 1, -1, FLT_NONE, 1, 1);
		send_image();
	endtask

	task automatic test_path_and_data();
		set_image_size(32'd4096);
		build_table(IMAGE_MAGIC, 32'd1, 1, 0, FLT_PLEN_ZERO, 1, 4);
		send_image();
		build_table(IMAGE_MAGIC, 32'd2, 2, 1, FLT_PLEN_HUGE, 1, 4);
		send_image();
		build_table(IMAGE_MAGIC, 32'd3, 3, 1, FLT_DATA_RANGE, 1, 8);
		send_image();
		build_table(IMAGE_MAGIC, 32'd1, 1, 0, FLT_PATH_AND_DATA, 1, 4);
		send_image();
		build_table(IMAGE_MAGIC, 32'd1, 1, -1, FLT_NONE, 255, 255);
		send_image();
	endtask

	task automatic test_restart();
		build_table(IMAGE_MAGIC, 32'd2, 2, -1, FLT_NONE, 1, 8);
		send_image(15);
		send_noise(3);
		send_image(img.size() - 1);
		send_image();
	endtask

	// largest declared count, table cut short by the image end or by a bad data range
	task automatic test_max_count();
		set_image_size(HEADER_BYTES + 32'd3 * (RECORD_BYTES + 32'd1));
		build_table(IMAGE_MAGIC, 32'(MAX_ENTRIES), 3, -1, FLT_NONE, 1, 1);
		send_image();
		set_image_size('1);
		build_table(IMAGE_MAGIC, 32'(MAX_ENTRIES), 3, 2, FLT_DATA_RANGE, 1, 1);
		send_image();
	endtask

	task automatic test_random_images();
		int r, n;
		logic [31:0] sz;
		while (n_sent < TOTAL_ITEMS) begin
			case ($urandom_range(0, 9))
				0: sz = $urandom_range(0, 7);
				1: sz = $urandom_range(8, 40);
				2, 3, 4: sz = $urandom_range(41, 300);
				5: sz = $urandom_range(301, 65535);
				6: sz = $urandom;
				7: sz = '1;
				default: sz = $urandom_range(60, 120);
			endcase
			set_image_size(sz);
			idle_on = (n_sent < TOTAL_ITEMS * 85 / 100) && ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(3, 12)) begin
				if (n_sent < TOTAL_ITEMS) begin
					if (n_sent >= TOTAL_ITEMS * 85 / 100)
						idle_on = 1'b0;
					r = $urandom_range(0, 99);
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16)
						: $urandom_range(1, 4);
					if (r < 60) begin
						if ($urandom_range(0, 2) == 0)
							build_table(IMAGE_MAGIC, n, n, $urandom_range(0, n - 1),
								table_fault_t'($urandom_range(1, 4)), 1, 8);
						else
							build_table(IMAGE_MAGIC, n, n, -1, FLT_NONE, 1,
								$urandom_range(0, 1) ? 8 : 40);
						send_image();
					end else if (r < 70) begin
						build_table(IMAGE_MAGIC, $urandom_range(1, MAX_ENTRIES), n, -1,
							FLT_NONE, 1, 8);
						send_image();
					end else if (r < 80) begin
						build_table(IMAGE_MAGIC, n, n, -1, FLT_NONE, 1, 8);
						send_image($urandom_range(1, img.size() - 1));
					end else if (r < 88) begin
						if ($urandom_range(0, 1))
							build_table(IMAGE_MAGIC ^ (32'd1 << $urandom_range(0, 31)), n, n,
								-1, FLT_NONE, 1, 8);
						else
							build_table(IMAGE_MAGIC, $urandom, n, -1, FLT_NONE, 1, 8);
						send_image();
					end else if (r < 94) begin
						img.delete();
						repeat ($urandom_range(1, 12)) img.push_back(8'($urandom_range(0, 255)));
						send_image();
					end else begin
						send_noise($urandom_range(1, 6));
					end
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			verdict_ch.ready <= 1'b0;
		end else if (ready_hold > 0) begin
			verdict_ch.ready <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			verdict_ch.ready <= 1'b0;
			ready_hold <= $urandom_range(0, 2);
		end else begin
			verdict_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		verdict_t want, got;
		if (arst_n && verdict_ch.valid && verdict_ch.ready) begin
			got.ok = verdict_ch.image_ok;
			got.kind = aihv_err_t'(verdict_ch.error_kind);
			got.count = verdict_ch.entry_count;
			got.bad = verdict_ch.bad_entry;
			n_results++;
			if (got.kind <= ERR_DATA)
				kind_seen[got.kind]++;
			if (pending_verdicts.size() == 0) begin
				want = '0;
				report_mismatch("verdict with none pending", want, got);
			end else begin
				want = pending_verdicts.pop_front();
				if (got.ok !== want.ok || got.kind !== want.kind
					|| got.count !== want.count || got.bad !== want.bad)
					report_mismatch("verdict mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t no transfer for %0d cycles", $realtime, quiet_cycles);
			$display("[archive_image_header_validator_unit] ERROR");
			$finish;
		end
	end

	initial begin
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= 8'd0;
		byte_ch.first_byte <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 32'd0;
		size_cfg = '0;
		parse_state = PH_IDLE;
		field_idx = '0;
		byte_pos = '0;
		shreg = '0;
		tbl_entries = '0;
		tbl_done = '0;
		cur_path_len = '0;
		cur_data_off = '0;
		path_remaining = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ignored_bytes();
		test_too_small();
		test_header_checks();
		test_record_bounds();
		test_path_and_data();
		test_restart();
		test_max_count();
		test_random_images();
		settle_block();

		$display("ran %0d images (%0d bytes sent, %0d parsed) over %0d image sizes, %0d verdicts",
			n_images, n_sent, n_parsed, n_sizes, n_results);
		$display("verdicts ok/small/magic/count/record/path/data: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
			kind_seen[5], kind_seen[6]);
		if (n_mismatch == 0)
			$display("[archive_image_header_validator_unit] OK");
		else
			$display("[archive_image_header_validator_unit] ERROR");
		$finish;
	end

endmodule

[archive_image_header_validator_unit.f]
+incdir+rtl/core
rtl/core/aihv_pkg.sv
rtl/core/aihv_channels.sv
rtl/core/aihv_parser.sv
rtl/core/archive_image_header_validator_unit.sv
bench/tb_archive_image_header_validator_unit.sv
